[hw/rtl/akc_pkg.sv]
`timescale 1ns / 1ps

package akc_pkg;

   // Default sizing of the sample table and of the per-entry frequency counter.
   localparam int unsigned DEF_TABLE_ENTRIES = 4096;
   localparam int unsigned DEF_COUNT_BITS    = 32;

   // Fixed widths of the item fields.
   localparam int unsigned HASH_W   = 64;
   localparam int unsigned LEVEL_W  = 6;
   localparam int unsigned THRESH_W = 7;
   localparam int unsigned MAXS_W   = 13;

   // Number of levels; the threshold saturates at this value.
   localparam logic [THRESH_W-1:0] LEVELS = 7'd64;

   // Reset value of the sample limit register.
   localparam logic [MAXS_W-1:0] MAXS_RESET = 13'd4096;

   // Level of a hash: number of trailing zero bits, with a zero hash at 63.
   function automatic logic [LEVEL_W-1:0] level_of(input logic [HASH_W-1:0] h);
      logic [LEVEL_W-1:0] n;
      n = LEVEL_W'(63);
      for (int i = HASH_W - 1; i >= 0; i--) begin
         if (h[i]) begin
            n = LEVEL_W'(i);
         end
      end
      return n;
   endfunction

endpackage

[hw/rtl/akc_table.sv]
`timescale 1ns / 1ps

module akc_table #(
   parameter int unsigned DEPTH  = akc_pkg::DEF_TABLE_ENTRIES,
   parameter int unsigned DATA_W = akc_pkg::DEF_COUNT_BITS + 71
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   import akc_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // One write port and one read port; read data is registered and appears in the cycle after the address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/adaptive_sampling_kmer_counter_core.sv]
`timescale 1ns / 1ps

// Channel   Ports                                    Direction  Notes
// req       req_valid, req_stall, req_kmer_hash      in         one hash per item
// rsp       rsp_valid, rsp_stall, rsp_*              out        one result per item
// csr       csr_wr_en, csr_wr_data                   in         max_samples, write only
//
// An item whose level is below the threshold skips the walk and goes straight to ST_FIN.
// A sampled item walks the table through the single read port of the table memory,
// one entry per cycle up to the fill mark, one past the highest entry ever written;
// the walk ends early on a hit. Each level drop is a further walk up to the fill
// mark. Reset is synchronous and needs no clearing pass: entries at or above the
// fill mark count as empty. A new item is taken only while the control is idle; a
// stalled result sits in the output register, and the next item then waits in ST_FIN.

module adaptive_sampling_kmer_counter_core #(
   parameter int unsigned TABLE_ENTRIES = akc_pkg::DEF_TABLE_ENTRIES,
   parameter int unsigned COUNT_BITS    = akc_pkg::DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [akc_pkg::HASH_W-1:0]    req_kmer_hash,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [akc_pkg::LEVEL_W-1:0]   rsp_level,
   output logic                          rsp_sampled,
   output logic                          rsp_was_new,
   output logic [31:0]                   rsp_frequency,
   output logic [akc_pkg::THRESH_W-1:0]  rsp_threshold_now,
   output logic [akc_pkg::MAXS_W-1:0]    rsp_samples_held,
   output logic [63:0]                   rsp_distinct_estimate,
   output logic [63:0]                   rsp_kmers_seen,
   output logic                          rsp_table_full,
   input  logic                          csr_wr_en,
   input  logic [akc_pkg::MAXS_W-1:0]    csr_wr_data
);

   import akc_pkg::*;

   localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int unsigned FILL_W = IDX_W + 1;
   // The sample count never exceeds the table size, and the port shows its low 13 bits.
   localparam int unsigned SC_W   = (FILL_W > MAXS_W) ? FILL_W : MAXS_W;
   localparam int unsigned DATA_W = COUNT_BITS + LEVEL_W + HASH_W + 1;
   localparam int unsigned EXT_W  = 64 + SC_W;

   // Entry layout in the table memory: valid, level, frequency, key.
   localparam int unsigned KEY_LO = 0;
   localparam int unsigned CNT_LO = HASH_W;
   localparam int unsigned LVL_LO = HASH_W + COUNT_BITS;
   localparam int unsigned VLD_B  = HASH_W + COUNT_BITS + LEVEL_W;

   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DROP = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [HASH_W-1:0]    hash_ff, hash_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic                 sampled_ff, sampled_in;
   logic                 was_new_ff, was_new_in;
   logic                 full_ff, full_in;
   logic [COUNT_BITS-1:0] freq_ff, freq_in;
   logic [THRESH_W-1:0]  th_ff, th_in;
   logic [SC_W-1:0]      sc_ff, sc_in;
   logic [63:0]          total_ff, total_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [MAXS_W-1:0]    maxs_ff, maxs_in;
   logic [FILL_W-1:0]    issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     raddr_ff, raddr_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [FILL_W-1:0]    dropped_ff, dropped_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   o_level_ff, o_level_in;
   logic                 o_sampled_ff, o_sampled_in;
   logic                 o_was_new_ff, o_was_new_in;
   logic [31:0]          o_freq_ff, o_freq_in;
   logic [THRESH_W-1:0]  o_th_ff, o_th_in;
   logic [MAXS_W-1:0]    o_sc_ff, o_sc_in;
   logic [63:0]          o_est_ff, o_est_in;
   logic [63:0]          o_total_ff, o_total_in;
   logic                 o_full_ff, o_full_in;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [DATA_W-1:0]    mem_wdata;
   logic                 mem_re;
   logic [DATA_W-1:0]    mem_rdata;

   logic                 req_take;
   logic [LEVEL_W-1:0]   req_lvl;
   logic                 e_valid;
   logic [LEVEL_W-1:0]   e_level;
   logic [COUNT_BITS-1:0] e_count;
   logic [HASH_W-1:0]    e_key;
   logic [SC_W-1:0]      sc_inc;
   logic [SC_W-1:0]      sc_after_drop;
   logic [THRESH_W-1:0]  th_inc;
   logic [EXT_W-1:0]     est_shift;
   logic [63:0]          est_val;

   akc_table #(
      .DEPTH  (TABLE_ENTRIES),
      .DATA_W (DATA_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign req_lvl   = level_of(req_kmer_hash);

   assign e_valid = mem_rdata[VLD_B];
   assign e_level = mem_rdata[LVL_LO +: LEVEL_W];
   assign e_count = mem_rdata[CNT_LO +: COUNT_BITS];
   assign e_key   = mem_rdata[KEY_LO +: HASH_W];

   assign sc_inc        = sc_ff + SC_W'(1);
   assign sc_after_drop = (SC_W'(dropped_ff) > sc_ff) ? '0 : sc_ff - SC_W'(dropped_ff);
   assign th_inc        = th_ff + THRESH_W'(1);

   // Estimate: sample count shifted left by the threshold, saturating at all ones.
   assign est_shift = EXT_W'(sc_ff) << th_ff[LEVEL_W-1:0];
   always_comb begin
      if (sc_ff == '0) begin
         est_val = '0;
      end else if (th_ff >= LEVELS || (|est_shift[EXT_W-1:64])) begin
         est_val = '1;
      end else begin
         est_val = est_shift[63:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      lvl_in        = lvl_ff;
      sampled_in    = sampled_ff;
      was_new_in    = was_new_ff;
      full_in       = full_ff;
      freq_in       = freq_ff;
      th_in         = th_ff;
      sc_in         = sc_ff;
      total_in      = total_ff;
      fill_in       = fill_ff;
      maxs_in       = csr_wr_en ? csr_wr_data : maxs_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      raddr_in      = raddr_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      dropped_in    = dropped_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      o_level_in    = o_level_ff;
      o_sampled_in  = o_sampled_ff;
      o_was_new_in  = o_was_new_ff;
      o_freq_in     = o_freq_ff;
      o_th_in       = o_th_ff;
      o_sc_in       = o_sc_ff;
      o_est_in      = o_est_ff;
      o_total_in    = o_total_ff;
      o_full_in     = o_full_ff;

      mem_we    = 1'b0;
      mem_waddr = raddr_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               hash_in       = req_kmer_hash;
               lvl_in        = req_lvl;
               total_in      = total_ff + 64'd1;
               sampled_in    = ({1'b0, req_lvl} >= th_ff);
               was_new_in    = 1'b0;
               full_in       = 1'b0;
               freq_in       = '0;
               issue_in      = '0;
               free_found_in = 1'b0;
               state_in      = ({1'b0, req_lvl} >= th_ff) ? ST_SCAN : ST_FIN;
            end
         end

         ST_SCAN: begin
            if (pend_ff && e_valid && e_key == hash_ff) begin
               // Hit: bump the frequency, saturating, and write the entry back.
               mem_we    = 1'b1;
               mem_waddr = raddr_ff;
               freq_in   = (e_count == '1) ? e_count : e_count + COUNT_BITS'(1);
               mem_wdata = {1'b1, e_level, freq_in, e_key};
               state_in  = ST_FIN;
            end else if (!pend_ff && issue_ff == fill_ff) begin
               // Walk finished without a hit: insert at the lowest free entry, or flag the table full.
               if (free_found_ff || fill_ff < FILL_MAX) begin
                  mem_we     = 1'b1;
                  mem_waddr  = free_found_ff ? free_idx_ff : fill_ff[IDX_W-1:0];
                  mem_wdata  = {1'b1, lvl_ff, COUNT_BITS'(1), hash_ff};
                  fill_in    = free_found_ff ? fill_ff : fill_ff + FILL_W'(1);
                  freq_in    = COUNT_BITS'(1);
                  was_new_in = 1'b1;
                  sc_in      = sc_inc;
                  issue_in   = '0;
                  dropped_in = '0;
                  if (sc_inc >= SC_W'(maxs_ff) && th_ff < LEVELS) begin
                     state_in = ST_DROP;
                  end else begin
                     state_in = ST_FIN;
                  end
               end else begin
                  full_in  = 1'b1;
                  state_in = ST_FIN;
               end
            end else begin
               if (pend_ff && !e_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = raddr_ff;
               end
               if (issue_ff < fill_ff) begin
                  mem_re   = 1'b1;
                  pend_in  = 1'b1;
                  raddr_in = issue_ff[IDX_W-1:0];
                  issue_in = issue_ff + FILL_W'(1);
               end
            end
         end

         ST_DROP: begin
            // Clear every valid entry of the threshold level, then raise the threshold.
            if (pend_ff && e_valid && e_level == th_ff[LEVEL_W-1:0]) begin
               mem_we     = 1'b1;
               mem_waddr  = raddr_ff;
               mem_wdata  = {1'b0, e_level, e_count, e_key};
               dropped_in = dropped_ff + FILL_W'(1);
            end
            if (!pend_ff && issue_ff == fill_ff) begin
               sc_in      = sc_after_drop;
               th_in      = th_inc;
               issue_in   = '0;
               dropped_in = '0;
               if (sc_after_drop >= SC_W'(maxs_ff) && th_inc < LEVELS) begin
                  state_in = ST_DROP;
               end else begin
                  state_in = ST_FIN;
               end
            end else if (issue_ff < fill_ff) begin
               mem_re   = 1'b1;
               pend_in  = 1'b1;
               raddr_in = issue_ff[IDX_W-1:0];
               issue_in = issue_ff + FILL_W'(1);
            end
         end

         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_level_in   = lvl_ff;
               o_sampled_in = sampled_ff;
               o_was_new_in = was_new_ff;
               o_freq_in    = 32'(freq_ff);
               o_th_in      = th_ff;
               o_sc_in      = sc_ff[MAXS_W-1:0];
               o_est_in     = est_val;
               o_total_in   = total_ff;
               o_full_in    = full_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         th_ff        <= '0;
         sc_ff        <= '0;
         total_ff     <= '0;
         fill_ff      <= '0;
         maxs_ff      <= MAXS_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         th_ff        <= th_in;
         sc_ff        <= sc_in;
         total_ff     <= total_in;
         fill_ff      <= fill_in;
         maxs_ff      <= maxs_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff       <= hash_in;
      lvl_ff        <= lvl_in;
      sampled_ff    <= sampled_in;
      was_new_ff    <= was_new_in;
      full_ff       <= full_in;
      freq_ff       <= freq_in;
      issue_ff      <= issue_in;
      raddr_ff      <= raddr_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      dropped_ff    <= dropped_in;
      o_level_ff    <= o_level_in;
      o_sampled_ff  <= o_sampled_in;
      o_was_new_ff  <= o_was_new_in;
      o_freq_ff     <= o_freq_in;
      o_th_ff       <= o_th_in;
      o_sc_ff       <= o_sc_in;
      o_est_ff      <= o_est_in;
      o_total_ff    <= o_total_in;
      o_full_ff     <= o_full_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_level             = o_level_ff;
   assign rsp_sampled           = o_sampled_ff;
   assign rsp_was_new           = o_was_new_ff;
   assign rsp_frequency         = o_freq_ff;
   assign rsp_threshold_now     = o_th_ff;
   assign rsp_samples_held      = o_sc_ff;
   assign rsp_distinct_estimate = o_est_ff;
   assign rsp_kmers_seen        = o_total_ff;
   assign rsp_table_full        = o_full_ff;

endmodule
